// ===== hdl/cltu_pkg.sv =====
// Shared constants, codes and types of the core-local interruptor timer unit.
`timescale 1ns / 1ps

package cltu_pkg;

    // Hart count and derived widths
    localparam int MAX_HARTS = 8;
    localparam int HART_W    = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
    localparam int CNT_W     = $clog2(MAX_HARTS + 1);
    localparam int LINE_W    = 8;
    localparam int LINE_N    = (MAX_HARTS < LINE_W) ? MAX_HARTS : LINE_W;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int OFF_W       = 16;
    localparam int BYTES_W     = 4;
    localparam int DATA_W      = 32;
    localparam int TIME_W      = 64;
    localparam int HARTS_CFG_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Only word accesses are legal
    localparam logic [BYTES_W-1:0] WORD_BYTES = 4'd4;

    // Register map
    localparam logic [OFF_W-1:0] SOFT_BASE = 16'h0000;
    localparam logic [OFF_W-1:0] CMP_BASE  = 16'h4000;
    localparam logic [OFF_W-1:0] TIME_LO   = 16'hbff8;
    localparam logic [OFF_W-1:0] TIME_HI   = 16'hbffc;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HARTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIM_MODE    = 1'd1;

    localparam logic [HARTS_CFG_W-1:0] HARTS_RESET = 4'd1;

    // Register targeted by one access
    typedef enum logic [1:0] {
        TGT_NONE,
        TGT_SOFT,
        TGT_CMP,
        TGT_TIME
    } target_t;

    // Decoded access, handed from the decoder to the register file
    typedef struct packed {
        logic              ok;
        logic              wr;
        logic              tick;
        target_t           target;
        logic [HART_W-1:0] hart;
        logic              upper;
    } access_t;

endpackage

// ===== hdl/cltu_decode.sv =====
// Address and width decode of one bus beat or tick for the interruptor timer unit.
`timescale 1ns / 1ps

module cltu_decode
(
    input  logic [cltu_pkg::CMD_W-1:0]   cmd,
    input  logic [cltu_pkg::OFF_W-1:0]   offset,
    input  logic [cltu_pkg::BYTES_W-1:0] access_bytes,
    input  logic [cltu_pkg::CNT_W-1:0]   harts_used,
    output cltu_pkg::access_t            acc
);

    localparam int LIM_W = cltu_pkg::OFF_W + 1;

    logic [LIM_W-1:0]          soft_end;
    logic [LIM_W-1:0]          cmp_end;
    logic [LIM_W-1:0]          off_ext;
    logic [cltu_pkg::OFF_W-1:0] soft_rel;
    logic [cltu_pkg::OFF_W-1:0] cmp_rel;

    // Region limits follow the number of harts in use
    assign soft_end = LIM_W'(cltu_pkg::SOFT_BASE) + (LIM_W'(harts_used) << 2);
    assign cmp_end  = LIM_W'(cltu_pkg::CMP_BASE) + (LIM_W'(harts_used) << 3);
    assign off_ext  = LIM_W'(offset);
    assign soft_rel = offset - cltu_pkg::SOFT_BASE;
    assign cmp_rel  = offset - cltu_pkg::CMP_BASE;

    // Classify the access: fail, pick a register, or fall through unmapped
    always_comb
    begin
        acc        = '0;
        acc.ok     = 1'b1;
        acc.target = cltu_pkg::TGT_NONE;
        acc.wr     = (cmd == cltu_pkg::CMD_WRITE);
        acc.tick   = (cmd == cltu_pkg::CMD_TICK);
        if (cmd == cltu_pkg::CMD_READ || cmd == cltu_pkg::CMD_WRITE)
        begin
            priority if (access_bytes != cltu_pkg::WORD_BYTES)
            begin
                acc.ok = 1'b0;
            end
            else if (off_ext < soft_end)
            begin
                if (soft_rel[1:0] != 2'b00)
                begin
                    acc.ok = 1'b0;
                end
                else
                begin
                    acc.target = cltu_pkg::TGT_SOFT;
                    acc.hart   = soft_rel[cltu_pkg::HART_W+1:2];
                end
            end
            else if (offset >= cltu_pkg::CMP_BASE && off_ext < cmp_end)
            begin
                if (cmp_rel[1:0] != 2'b00)
                begin
                    acc.ok = 1'b0;
                end
                else
                begin
                    acc.target = cltu_pkg::TGT_CMP;
                    acc.hart   = cmp_rel[cltu_pkg::HART_W+2:3];
                    acc.upper  = cmp_rel[2];
                end
            end
            else if (offset == cltu_pkg::TIME_LO || offset == cltu_pkg::TIME_HI)
            begin
                acc.target = cltu_pkg::TGT_TIME;
                acc.upper  = (offset == cltu_pkg::TIME_HI);
            end
            else
            begin
                // Unmapped: reads give zero, writes drop
            end
        end
    end

endmodule

// ===== hdl/cltu_state.sv =====
// Software bits, compare values, time counter and interrupt comparators.
`timescale 1ns / 1ps

module cltu_state
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  cltu_pkg::access_t             acc,
    input  logic [cltu_pkg::DATA_W-1:0]   write_data,
    input  logic [cltu_pkg::CNT_W-1:0]    harts_used,
    input  logic                          shim,
    output logic [cltu_pkg::DATA_W-1:0]   read_data,
    output logic [cltu_pkg::LINE_W-1:0]   soft_lines,
    output logic [cltu_pkg::LINE_W-1:0]   mt_lines,
    output logic [cltu_pkg::LINE_W-1:0]   st_lines,
    output logic [cltu_pkg::LINE_W-1:0]   wake_lines
);

    localparam int DW = cltu_pkg::DATA_W;
    localparam int TW = cltu_pkg::TIME_W;

    logic [cltu_pkg::MAX_HARTS-1:0] soft_reg;
    logic [cltu_pkg::MAX_HARTS-1:0] soft_next;
    logic [TW-1:0]                  cmp_reg  [cltu_pkg::MAX_HARTS];
    logic [TW-1:0]                  cmp_next [cltu_pkg::MAX_HARTS];
    logic [TW-1:0]                  time_reg;
    logic [TW-1:0]                  time_next;

    // Apply the access to a copy of the state and pick the read word
    always_comb
    begin
        soft_next = soft_reg;
        cmp_next  = cmp_reg;
        time_next = time_reg;
        read_data = '0;
        if (acc.tick)
        begin
            time_next = time_reg + TW'(1);
        end
        unique case (acc.target)
            cltu_pkg::TGT_SOFT:
            begin
                if (acc.wr)
                    soft_next[acc.hart] = write_data[0];
                else
                    read_data = DW'(soft_reg[acc.hart]);
            end
            cltu_pkg::TGT_CMP:
            begin
                if (acc.wr && acc.upper)
                    cmp_next[acc.hart][TW-1:DW] = write_data;
                else if (acc.wr)
                    cmp_next[acc.hart][DW-1:0] = write_data;
                else if (acc.upper)
                    read_data = cmp_reg[acc.hart][TW-1:DW];
                else
                    read_data = cmp_reg[acc.hart][DW-1:0];
            end
            cltu_pkg::TGT_TIME:
            begin
                if (acc.wr && acc.upper)
                    time_next[TW-1:DW] = write_data;
                else if (acc.wr)
                    time_next[DW-1:0] = write_data;
                else if (acc.upper)
                    read_data = time_reg[TW-1:DW];
                else
                    read_data = time_reg[DW-1:0];
            end
            cltu_pkg::TGT_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Drive per-hart lines from the updated state
    genvar h;
    generate
        for (h = 0; h < cltu_pkg::LINE_N; h++)
        begin : g_line
            logic active;
            logic expired;
            assign active        = (cltu_pkg::CNT_W'(h) < harts_used);
            assign expired       = (time_next >= cmp_next[h]);
            assign soft_lines[h] = active & soft_next[h];
            assign mt_lines[h]   = active & expired & ~shim;
            assign st_lines[h]   = active & expired & shim;
            assign wake_lines[h] = (acc.target == cltu_pkg::TGT_SOFT) & acc.wr &
                                   write_data[0] & (acc.hart == cltu_pkg::HART_W'(h));
        end
        if (cltu_pkg::LINE_N < cltu_pkg::LINE_W)
        begin : g_unused
            assign soft_lines[cltu_pkg::LINE_W-1:cltu_pkg::LINE_N] = '0;
            assign mt_lines[cltu_pkg::LINE_W-1:cltu_pkg::LINE_N]   = '0;
            assign st_lines[cltu_pkg::LINE_W-1:cltu_pkg::LINE_N]   = '0;
            assign wake_lines[cltu_pkg::LINE_W-1:cltu_pkg::LINE_N] = '0;
        end
    endgenerate

    // Commit the state when the beat leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_reg <= '0;
            time_reg <= '0;
            for (int i = 0; i < cltu_pkg::MAX_HARTS; i++)
            begin
                cmp_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            soft_reg <= soft_next;
            time_reg <= time_next;
            cmp_reg  <= cmp_next;
        end
    end

endmodule

// ===== hdl/core_local_interruptor_timer_unit.sv =====
// Top level of the core-local interruptor timer unit: handshakes, config and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  req     | in        | req_valid/req_stall | cmd, offset, access_bytes, write_data
//  rsp     | out       | rsp_valid/rsp_stall | access_ok, read_data, *_lines
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while req_stall is low: a beat is registered on entry, decoded, applied
// to the state, compared against all compare values and lands in the result register.
// rsp_valid rises when the beat moves from the input register into the result register.
// req_stall is high only while both registers hold a beat and rsp_stall is high.
// Reset clears all software bits, compare values and the time counter; active harts is 1.
`timescale 1ns / 1ps

module core_local_interruptor_timer_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [cltu_pkg::CMD_W-1:0]        cmd,
    input  logic [cltu_pkg::OFF_W-1:0]        offset,
    input  logic [cltu_pkg::BYTES_W-1:0]      access_bytes,
    input  logic [cltu_pkg::DATA_W-1:0]       write_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              access_ok,
    output logic [cltu_pkg::DATA_W-1:0]       read_data,
    output logic [cltu_pkg::LINE_W-1:0]       soft_irq_lines,
    output logic [cltu_pkg::LINE_W-1:0]       machine_timer_lines,
    output logic [cltu_pkg::LINE_W-1:0]       supervisor_timer_lines,
    output logic [cltu_pkg::LINE_W-1:0]       wake_lines,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cltu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cltu_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CLW = 8;

    // Configuration
    logic [cltu_pkg::HARTS_CFG_W-1:0] harts_reg;
    logic                             shim_reg;
    logic [cltu_pkg::CNT_W-1:0]       harts_used;

    // Input register
    logic                           req_valid_reg;
    logic [cltu_pkg::CMD_W-1:0]     cmd_reg;
    logic [cltu_pkg::OFF_W-1:0]     offset_reg;
    logic [cltu_pkg::BYTES_W-1:0]   bytes_reg;
    logic [cltu_pkg::DATA_W-1:0]    wdata_reg;

    // Result register
    logic                           rsp_valid_reg;
    logic                           ok_reg;
    logic [cltu_pkg::DATA_W-1:0]    rdata_reg;
    logic [cltu_pkg::LINE_W-1:0]    soft_reg;
    logic [cltu_pkg::LINE_W-1:0]    mt_reg;
    logic [cltu_pkg::LINE_W-1:0]    st_reg;
    logic [cltu_pkg::LINE_W-1:0]    wake_reg;

    logic                           out_free;
    logic                           fire;
    logic                           req_take;
    cltu_pkg::access_t              acc;
    logic [cltu_pkg::DATA_W-1:0]    rdata_next;
    logic [cltu_pkg::LINE_W-1:0]    soft_next;
    logic [cltu_pkg::LINE_W-1:0]    mt_next;
    logic [cltu_pkg::LINE_W-1:0]    st_next;
    logic [cltu_pkg::LINE_W-1:0]    wake_next;

    // Flow control
    assign out_free  = ~rsp_valid_reg | ~rsp_stall;
    assign fire      = req_valid_reg & out_free;
    assign req_stall = req_valid_reg & ~out_free;
    assign req_take  = req_valid & ~req_stall;
    assign cfg_ready = 1'b1;

    // Clamp the hart count to the supported range
    always_comb
    begin
        priority if (harts_reg == '0)
            harts_used = cltu_pkg::CNT_W'(1);
        else if (CLW'(harts_reg) > CLW'(cltu_pkg::MAX_HARTS))
            harts_used = cltu_pkg::CNT_W'(cltu_pkg::MAX_HARTS);
        else
            harts_used = cltu_pkg::CNT_W'(harts_reg);
    end

    // Hold configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harts_reg <= cltu_pkg::HARTS_RESET;
            shim_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cltu_pkg::CFG_ACTIVE_HARTS: harts_reg <= cfg_data;
                cltu_pkg::CFG_SHIM_MODE:    shim_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Capture an incoming beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (req_take)
            req_valid_reg <= 1'b1;
        else if (fire)
            req_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg    <= cmd;
            offset_reg <= offset;
            bytes_reg  <= access_bytes;
            wdata_reg  <= write_data;
        end
    end

    cltu_decode u_decode
    (
        .cmd          (cmd_reg),
        .offset       (offset_reg),
        .access_bytes (bytes_reg),
        .harts_used   (harts_used),
        .acc          (acc)
    );

    cltu_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .acc        (acc),
        .write_data (wdata_reg),
        .harts_used (harts_used),
        .shim       (shim_reg),
        .read_data  (rdata_next),
        .soft_lines (soft_next),
        .mt_lines   (mt_next),
        .st_lines   (st_next),
        .wake_lines (wake_next)
    );

    // Advance the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (fire)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg    <= acc.ok;
            rdata_reg <= rdata_next;
            soft_reg  <= soft_next;
            mt_reg    <= mt_next;
            st_reg    <= st_next;
            wake_reg  <= wake_next;
        end
    end

    assign rsp_valid              = rsp_valid_reg;
    assign access_ok              = ok_reg;
    assign read_data              = rdata_reg;
    assign soft_irq_lines         = soft_reg;
    assign machine_timer_lines    = mt_reg;
    assign supervisor_timer_lines = st_reg;
    assign wake_lines             = wake_reg;

    // Checks
    a_wake_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(wake_lines))
        else $error("wake lines not one-hot");

    a_timer_route: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (machine_timer_lines == '0 || supervisor_timer_lines == '0))
        else $error("timer expiry on both machine and supervisor lines");

    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !access_ok) |-> (read_data == '0 && wake_lines == '0))
        else $error("failed access returned data or wake");

    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !fire) |=> (req_valid_reg && $stable(offset_reg) && $stable(cmd_reg)))
        else $error("held beat lost from input register");

endmodule
